// ===== rtl/pltd_pkg.sv =====
`default_nettype none

package pltd_pkg;

    // command codes
    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_BEGIN = 2'd0;
    localparam cmd_t CMD_SEEN  = 2'd1;
    localparam cmd_t CMD_END   = 2'd2;
    localparam cmd_t CMD_CLEAR = 2'd3;

    // result kinds
    localparam logic EV_ACK   = 1'b0;
    localparam logic EV_EVICT = 1'b1;

    localparam int CAP_BITS = 6;
    localparam int SER_BITS = 64;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 6'd20;

    typedef logic [CAP_BITS-1:0] cap_t;
    typedef logic [SER_BITS-1:0] serial_t;

endpackage

`default_nettype wire

// ===== rtl/presence_aware_lru_device_table.sv =====
`default_nettype none

// Presence-aware LRU device table. Holds up to STORE_DEPTH device keys with a
// presence flag and a 64-bit sighting serial each. Commands: begin snapshot
// (all entries absent), seen (insert or refresh a key, stamp the next serial;
// key 0 is ignored; a new key with no free slot is dropped and flagged), end
// snapshot (evict until at most capacity_limit entries remain, absent entries
// first, then oldest serial, lowest slot on ties; each eviction is its own
// request on the output before the acknowledgement), clear (empty the table
// silently, restart the serial). One command is worked at a time and in_stall
// is high until its acknowledgement has been loaded into the output register.
// Each scan reads the key/serial memories through a single read port, one slot
// per cycle, with one shared compare unit. Begin snapshot, clear and a seen
// command with key 0 do not scan; a seen command with a nonzero key scans the
// store once, and end snapshot scans it once per eviction and waits whenever
// the output side stalls.
// capacity_limit is written through the cfg channel (always ready) and takes
// effect at the next capacity check of an end snapshot, also one under way.
module presence_aware_lru_device_table #(
    parameter int STORE_DEPTH = 32,
    parameter int KEY_BITS    = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // command channel
    input  wire logic                  in_valid,
    output      logic                  in_stall,
    input  wire pltd_pkg::cmd_t        cmd,
    input  wire logic [KEY_BITS-1:0]   device_key,
    input  wire logic                  is_default,
    // result channel
    output      logic                  out_valid,
    input  wire logic                  out_stall,
    output      logic                  event_res,
    output      logic [KEY_BITS-1:0]   result_key,
    output      logic                  was_known,
    output      logic                  dropped,
    output      logic                  last,
    // capacity register write
    input  wire logic                  cfg_valid,
    output      logic                  cfg_ready,
    input  wire pltd_pkg::cap_t        cfg_data
);

    import pltd_pkg::*;

    localparam int IDXW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNTW = $clog2(STORE_DEPTH + 1);
    localparam int CMPW = (CNTW > CAP_BITS) ? CNTW : CAP_BITS;
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(STORE_DEPTH - 1);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;  // walk the store, one slot per cycle
    localparam logic [2:0] S_UPD   = 3'd2;  // write back the seen key
    localparam logic [2:0] S_EVCHK = 3'd3;  // over capacity?
    localparam logic [2:0] S_EVOUT = 3'd4;  // report and drop the victim
    localparam logic [2:0] S_ACK   = 3'd5;  // acknowledgement

    logic [2:0]             state_reg, state_next;

    // scan pipeline: issue read at scan_idx, check in the cycle after
    logic [IDXW-1:0]        scan_idx_reg, scan_idx_next;
    logic                   scan_done_reg, scan_done_next;
    logic                   chk_vld_reg, chk_vld_next;
    logic [IDXW-1:0]        chk_idx_reg, chk_idx_next;
    logic                   issue;

    // latched request
    cmd_t                   cmd_reg, cmd_next;
    logic [KEY_BITS-1:0]    key_reg, key_next;
    logic                   dflt_in_reg, dflt_in_next;

    // seen search results
    logic                   hit_found_reg, hit_found_next;
    logic [IDXW-1:0]        hit_idx_reg, hit_idx_next;
    logic                   free_found_reg, free_found_next;
    logic [IDXW-1:0]        free_idx_reg, free_idx_next;

    // victim search results
    logic                   best_found_reg, best_found_next;
    logic [IDXW-1:0]        best_idx_reg, best_idx_next;
    logic                   best_present_reg, best_present_next;
    serial_t                best_ser_reg, best_ser_next;
    logic [KEY_BITS-1:0]    best_key_reg, best_key_next;

    // per-slot flags in flops, cleared at once
    logic [STORE_DEPTH-1:0] valid_reg, valid_next;
    logic [STORE_DEPTH-1:0] present_reg, present_next;
    logic [STORE_DEPTH-1:0] dflt_reg, dflt_next;

    logic [CNTW-1:0]        count_reg, count_next;
    serial_t                ctr_reg, ctr_next;
    cap_t                   cap_reg, cap_next;

    // acknowledgement flags
    logic                   ack_known_reg, ack_known_next;
    logic                   ack_drop_reg, ack_drop_next;

    // output register
    logic                   out_valid_reg, out_valid_next;
    logic                   event_reg, event_next;
    logic [KEY_BITS-1:0]    rkey_reg, rkey_next;
    logic                   known_reg, known_next;
    logic                   drop_reg, drop_next;
    logic                   last_reg, last_next;
    logic                   out_free;

    // key and serial memories, one write and one read port
    logic [KEY_BITS-1:0]    key_mem [STORE_DEPTH];
    serial_t                ser_mem [STORE_DEPTH];
    logic [KEY_BITS-1:0]    rd_key_reg;
    serial_t                rd_ser_reg;
    logic                   mem_we;
    logic [IDXW-1:0]        mem_waddr;

    // shared compare unit inputs
    logic                   ent_valid;
    logic                   ent_present;
    logic                   better;
    logic                   over_cap;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[mem_waddr] <= key_reg;
            ser_mem[mem_waddr] <= ctr_reg + SER_BITS'(1);
        end
        rd_key_reg <= key_mem[scan_idx_reg];
        rd_ser_reg <= ser_mem[scan_idx_reg];
    end

    assign out_free  = !out_valid_reg || !out_stall;
    assign issue     = (state_reg == S_SCAN) && !scan_done_reg;
    assign ent_valid   = valid_reg[chk_idx_reg];
    assign ent_present = present_reg[chk_idx_reg];
    assign over_cap  = CMPW'(count_reg) > CMPW'(cap_reg);

    // victim order: absent before present, then older serial; strict so the
    // lowest slot wins a tie
    assign better = !best_found_reg
                 || (best_present_reg && !ent_present)
                 || ((best_present_reg == ent_present) && (rd_ser_reg < best_ser_reg));

    always_comb
    begin
        state_next        = state_reg;
        scan_idx_next     = scan_idx_reg;
        scan_done_next    = scan_done_reg;
        chk_vld_next      = 1'b0;
        chk_idx_next      = chk_idx_reg;
        cmd_next          = cmd_reg;
        key_next          = key_reg;
        dflt_in_next      = dflt_in_reg;
        hit_found_next    = hit_found_reg;
        hit_idx_next      = hit_idx_reg;
        free_found_next   = free_found_reg;
        free_idx_next     = free_idx_reg;
        best_found_next   = best_found_reg;
        best_idx_next     = best_idx_reg;
        best_present_next = best_present_reg;
        best_ser_next     = best_ser_reg;
        best_key_next     = best_key_reg;
        valid_next        = valid_reg;
        present_next      = present_reg;
        dflt_next         = dflt_reg;
        count_next        = count_reg;
        ctr_next          = ctr_reg;
        cap_next          = cap_reg;
        ack_known_next    = ack_known_reg;
        ack_drop_next     = ack_drop_reg;
        out_valid_next    = out_valid_reg && out_stall;
        event_next        = event_reg;
        rkey_next         = rkey_reg;
        known_next        = known_reg;
        drop_next         = drop_reg;
        last_next         = last_reg;
        mem_we            = 1'b0;
        mem_waddr         = hit_found_reg ? hit_idx_reg : free_idx_reg;

        if (cfg_valid)
        begin
            cap_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next       = cmd;
                    key_next       = device_key;
                    dflt_in_next   = is_default;
                    ack_known_next = 1'b0;
                    ack_drop_next  = 1'b0;
                    case (cmd)
                        CMD_BEGIN:
                        begin
                            present_next = '0;
                            dflt_next    = '0;
                            state_next   = S_ACK;
                        end
                        CMD_SEEN:
                        begin
                            if (device_key == '0)
                            begin
                                state_next = S_ACK;
                            end
                            else
                            begin
                                scan_idx_next   = '0;
                                scan_done_next  = 1'b0;
                                hit_found_next  = 1'b0;
                                free_found_next = 1'b0;
                                state_next      = S_SCAN;
                            end
                        end
                        CMD_END:
                        begin
                            state_next = S_EVCHK;
                        end
                        default:
                        begin
                            valid_next = '0;
                            count_next = '0;
                            ctr_next   = '0;
                            state_next = S_ACK;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (issue)
                begin
                    scan_idx_next  = scan_idx_reg + IDXW'(1);
                    scan_done_next = (scan_idx_reg == LAST_IDX);
                end
                chk_vld_next = issue;
                chk_idx_next = scan_idx_reg;

                if (chk_vld_reg)
                begin
                    if (cmd_reg == CMD_SEEN)
                    begin
                        if (ent_valid && !hit_found_reg && (rd_key_reg == key_reg))
                        begin
                            hit_found_next = 1'b1;
                            hit_idx_next   = chk_idx_reg;
                        end
                        if (!ent_valid && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = chk_idx_reg;
                        end
                    end
                    else if (ent_valid && better)
                    begin
                        best_found_next   = 1'b1;
                        best_idx_next     = chk_idx_reg;
                        best_present_next = ent_present;
                        best_ser_next     = rd_ser_reg;
                        best_key_next     = rd_key_reg;
                    end

                    if (chk_idx_reg == LAST_IDX)
                    begin
                        state_next = (cmd_reg == CMD_SEEN) ? S_UPD : S_EVOUT;
                    end
                end
            end

            S_UPD:
            begin
                if (hit_found_reg || free_found_reg)
                begin
                    mem_we                  = 1'b1;
                    valid_next[mem_waddr]   = 1'b1;
                    present_next[mem_waddr] = 1'b1;
                    dflt_next[mem_waddr]    = dflt_in_reg;
                    ctr_next                = ctr_reg + SER_BITS'(1);
                    ack_known_next          = hit_found_reg;
                    if (!hit_found_reg)
                    begin
                        count_next = count_reg + CNTW'(1);
                    end
                end
                else
                begin
                    ack_drop_next = 1'b1;
                end
                state_next = S_ACK;
            end

            S_EVCHK:
            begin
                if (over_cap)
                begin
                    scan_idx_next   = '0;
                    scan_done_next  = 1'b0;
                    best_found_next = 1'b0;
                    state_next      = S_SCAN;
                end
                else
                begin
                    state_next = S_ACK;
                end
            end

            S_EVOUT:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    event_next               = EV_EVICT;
                    rkey_next                = best_key_reg;
                    known_next               = 1'b0;
                    drop_next                = 1'b0;
                    last_next                = 1'b0;
                    valid_next[best_idx_reg] = 1'b0;
                    count_next               = count_reg - CNTW'(1);
                    state_next               = S_EVCHK;
                end
            end

            S_ACK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    event_next     = EV_ACK;
                    rkey_next      = (cmd_reg == CMD_SEEN) ? key_reg : '0;
                    known_next     = ack_known_reg;
                    drop_next      = ack_drop_reg;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            scan_idx_reg     <= '0;
            scan_done_reg    <= 1'b0;
            chk_vld_reg      <= 1'b0;
            chk_idx_reg      <= '0;
            cmd_reg          <= CMD_BEGIN;
            key_reg          <= '0;
            dflt_in_reg      <= 1'b0;
            hit_found_reg    <= 1'b0;
            hit_idx_reg      <= '0;
            free_found_reg   <= 1'b0;
            free_idx_reg     <= '0;
            best_found_reg   <= 1'b0;
            best_idx_reg     <= '0;
            best_present_reg <= 1'b0;
            best_ser_reg     <= '0;
            best_key_reg     <= '0;
            valid_reg        <= '0;
            present_reg      <= '0;
            dflt_reg         <= '0;
            count_reg        <= '0;
            ctr_reg          <= '0;
            cap_reg          <= CAP_RESET;
            ack_known_reg    <= 1'b0;
            ack_drop_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            event_reg        <= EV_ACK;
            rkey_reg         <= '0;
            known_reg        <= 1'b0;
            drop_reg         <= 1'b0;
            last_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            scan_idx_reg     <= scan_idx_next;
            scan_done_reg    <= scan_done_next;
            chk_vld_reg      <= chk_vld_next;
            chk_idx_reg      <= chk_idx_next;
            cmd_reg          <= cmd_next;
            key_reg          <= key_next;
            dflt_in_reg      <= dflt_in_next;
            hit_found_reg    <= hit_found_next;
            hit_idx_reg      <= hit_idx_next;
            free_found_reg   <= free_found_next;
            free_idx_reg     <= free_idx_next;
            best_found_reg   <= best_found_next;
            best_idx_reg     <= best_idx_next;
            best_present_reg <= best_present_next;
            best_ser_reg     <= best_ser_next;
            best_key_reg     <= best_key_next;
            valid_reg        <= valid_next;
            present_reg      <= present_next;
            dflt_reg         <= dflt_next;
            count_reg        <= count_next;
            ctr_reg          <= ctr_next;
            cap_reg          <= cap_next;
            ack_known_reg    <= ack_known_next;
            ack_drop_reg     <= ack_drop_next;
            out_valid_reg    <= out_valid_next;
            event_reg        <= event_next;
            rkey_reg         <= rkey_next;
            known_reg        <= known_next;
            drop_reg         <= drop_next;
            last_reg         <= last_next;
        end
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign event_res  = event_reg;
    assign result_key = rkey_reg;
    assign was_known  = known_reg;
    assign dropped    = drop_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire

// ===== rtl/pltd_checker.sv =====
`default_nettype none

module pltd_checker #(
    parameter int KEY_BITS = 32
) (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_stall,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire logic                event_res,
    input wire logic [KEY_BITS-1:0] result_key,
    input wire logic                was_known,
    input wire logic                dropped,
    input wire logic                last
);

    import pltd_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_key) && $stable(last))
        else $error("stalled result changed");

    // the block stalls its input in the cycle after accepting a command
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted back to back");

    // only eviction reports precede the acknowledgement
    a_non_last_is_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> event_res == EV_EVICT && !was_known && !dropped)
        else $error("non-final result is not an eviction report");

    // a dropped key was never known, and the report is an acknowledgement
    a_drop_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dropped |-> !was_known && event_res == EV_ACK && last)
        else $error("inconsistent drop flags");

endmodule

bind presence_aware_lru_device_table pltd_checker #(
    .KEY_BITS (KEY_BITS)
) u_pltd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_res  (event_res),
    .result_key (result_key),
    .was_known  (was_known),
    .dropped    (dropped),
    .last       (last)
);

`default_nettype wire
